// File: hw/rtl/pfrt_pkg.sv
// Package for the position frame receiver: widths, protocol constants,
// parser phase type, the parser verdict struct and the output result struct.
// No dependencies.
package pfrt_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int POS_WORDS     = 4;
  localparam int TGT_WORDS     = 3;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] KIND_POS    = 8'h01;
  localparam logic [BYTE_W-1:0] KIND_TGT    = 8'h02;
  localparam logic [BYTE_W-1:0] LEN_POS     = 8'd8;
  localparam logic [BYTE_W-1:0] LEN_TGT     = 8'd6;

  localparam logic [WORD_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [WORD_W-1:0] TIMER_MAX     = 16'hFFFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_TYPE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef logic [WORD_W-1:0] word_t;

  // Parser verdict for the byte currently presented.
  typedef struct packed {
    logic                         good;
    logic                         load_pos;
    logic                         load_tgt;
    word_t [POS_WORDS-1:0]        pos;
    word_t [TGT_WORDS-1:0]        tgt;
  } parse_res_t;

  typedef struct packed {
    word_t [POS_WORDS-1:0]        pos;
    word_t [TGT_WORDS-1:0]        tgt;
    logic                         offline;
    logic                         good;
  } result_t;

endpackage

// File: hw/rtl/pfrt_parser.sv
// Frame parser: header, length, type, data, checksum.
// Holds the payload bytes, decodes words from them and checks the checksum.
// Depends on pfrt_pkg.
module pfrt_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_en,
  input  logic [pfrt_pkg::BYTE_W-1:0] rx_byte,
  output pfrt_pkg::parse_res_t        res
);
  import pfrt_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   length_r, length_nxt;
  logic [BYTE_W-1:0]   kind_r, kind_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [BYTE_W-1:0]   payload_r [PAYLOAD_BYTES];
  logic                store_en;
  logic [CNT_W-1:0]    cnt_inc;

  assign cnt_inc = count_r + CNT_W'(1);

  always_comb begin
    phase_nxt    = phase_r;
    length_nxt   = length_r;
    kind_nxt     = kind_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    store_en     = 1'b0;
    res.good     = 1'b0;
    res.load_pos = 1'b0;
    res.load_tgt = 1'b0;
    for (int i = 0; i < POS_WORDS; i++) begin
      res.pos[i] = {payload_r[2*i+1], payload_r[2*i]};
    end
    for (int i = 0; i < TGT_WORDS; i++) begin
      res.tgt[i] = {payload_r[2*i+1], payload_r[2*i]};
    end
    unique case (phase_r)
      PH_HEADER: begin
        if (rx_byte == HEADER_BYTE) begin
          sum_nxt   = '0;
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        length_nxt = rx_byte;
        sum_nxt    = sum_r + rx_byte;
        count_nxt  = '0;
        phase_nxt  = PH_TYPE;
      end
      PH_TYPE: begin
        kind_nxt  = rx_byte;
        sum_nxt   = sum_r + rx_byte;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (count_r < CNT_W'(PAYLOAD_BYTES)) begin
          store_en  = 1'b1;
          sum_nxt   = sum_r + rx_byte;
          count_nxt = cnt_inc;
        end
        if ({{(BYTE_W-CNT_W){1'b0}}, count_nxt} >= length_r ||
            count_nxt >= CNT_W'(PAYLOAD_BYTES)) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (sum_r == rx_byte) begin
          res.good     = 1'b1;
          res.load_pos = (kind_r == KIND_POS) && (length_r == LEN_POS);
          res.load_tgt = (kind_r == KIND_TGT) && (length_r == LEN_TGT);
        end
        phase_nxt = PH_HEADER;
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      length_r <= '0;
      kind_r   <= '0;
      count_r  <= '0;
      sum_r    <= '0;
    end else if (byte_en) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      kind_r   <= kind_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && store_en) begin
      payload_r[count_r[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// File: hw/rtl/position_frame_receiver_with_timeout.sv
// Top level of the position frame receiver with link timeout.
// Instantiates pfrt_parser; depends on pfrt_pkg.
//
// Each request is a received byte or a timer tick and yields exactly one
// result carrying all seven words, the offline flag and a frame-good strobe.
// One request is taken per cycle while in_stall is low. Its result is
// registered in a two-entry output buffer (result register plus skid)
// that lets requests keep flowing while a result waits; in_stall rises
// only when both entries are full, and is held high in reset. cfg_ready is
// high whenever out of reset; write timeout_ms only while the block is idle.
module position_frame_receiver_with_timeout (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [pfrt_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic [pfrt_pkg::BYTE_W-1:0]   in_tick_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_position_x,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_position_y,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_heading_x,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_heading_y,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_target_x,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_target_y,
  output logic signed [pfrt_pkg::WORD_W-1:0] out_target_z,
  output logic                          out_link_offline,
  output logic                          out_frame_good,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfrt_pkg::WORD_W-1:0]   cfg_timeout_ms
);
  import pfrt_pkg::*;

  logic                   in_acc;
  logic                   byte_en;
  logic                   out_take;
  parse_res_t             pres;

  logic [WORD_W-1:0]      timeout_r;
  logic [WORD_W-1:0]      timer_r, timer_nxt;
  logic                   offline_r, offline_nxt;
  word_t [POS_WORDS-1:0]  pos_r, pos_nxt;
  word_t [TGT_WORDS-1:0]  tgt_r, tgt_nxt;
  logic [WORD_W:0]        timer_sum;
  result_t                res_nxt;
  result_t                main_r, skid_r;
  logic                   main_valid_r, skid_valid_r;

  assign in_stall  = skid_valid_r || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign byte_en   = in_acc && (in_operation == OP_BYTE);
  assign out_take  = main_valid_r && !out_stall;
  assign cfg_ready = rst_n;

  pfrt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_rx_byte),
    .res     (pres)
  );

  assign timer_sum = {1'b0, timer_r} + {{(WORD_W+1-BYTE_W){1'b0}}, in_tick_ms};

  always_comb begin
    timer_nxt   = timer_r;
    offline_nxt = offline_r;
    pos_nxt     = pos_r;
    tgt_nxt     = tgt_r;
    if (in_operation == OP_TICK) begin
      if (timer_r < timeout_r) begin
        timer_nxt = timer_sum[WORD_W] ? TIMER_MAX : timer_sum[WORD_W-1:0];
      end else begin
        offline_nxt = 1'b1;
        pos_nxt     = '0;
        tgt_nxt     = '0;
      end
    end else if (pres.good) begin
      timer_nxt   = '0;
      offline_nxt = 1'b0;
      if (pres.load_pos) pos_nxt = pres.pos;
      if (pres.load_tgt) tgt_nxt = pres.tgt;
    end
    res_nxt.pos     = pos_nxt;
    res_nxt.tgt     = tgt_nxt;
    res_nxt.offline = offline_nxt;
    res_nxt.good    = (in_operation == OP_BYTE) && pres.good;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      timer_r   <= '0;
      offline_r <= 1'b0;
      pos_r     <= '0;
      tgt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_timeout_ms;
      if (in_acc) begin
        timer_r   <= timer_nxt;
        offline_r <= offline_nxt;
        pos_r     <= pos_nxt;
        tgt_r     <= tgt_nxt;
      end
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!main_valid_r || out_take) begin
        main_r       <= res_nxt;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      main_valid_r <= 1'b0;
    end
  end

  assign out_valid        = main_valid_r;
  assign out_position_x   = main_r.pos[0];
  assign out_position_y   = main_r.pos[1];
  assign out_heading_x    = main_r.pos[2];
  assign out_heading_y    = main_r.pos[3];
  assign out_target_x     = main_r.tgt[0];
  assign out_target_y     = main_r.tgt[1];
  assign out_target_z     = main_r.tgt[2];
  assign out_link_offline = main_r.offline;
  assign out_frame_good   = main_r.good;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty result register");

  a_good_not_offline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_good) |-> !out_link_offline)
    else $error("good frame reported while offline");

  a_offline_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(offline_r) |-> $past(in_acc && (in_operation == OP_TICK)))
    else $error("offline set without an accepted tick");

endmodule
